>>> design/dkec_pkg.sv
// ----------------------------------------------------------------------------
// dkec_pkg
// Shared types and constants of the display key emulation controller.
// ----------------------------------------------------------------------------
package dkec_pkg;

    // Fixed widths
    localparam int LEVEL_W    = 12;
    localparam int TICK_W     = 32;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Timing windows, in ticks
    localparam logic [TICK_W-1:0] HOLDOFF_TICKS     = 32'd75;
    localparam logic [TICK_W-1:0] MENU_WINDOW_TICKS = 32'd200;

    // Result queue: one poll yields up to two results
    localparam int MAX_RESULTS = 2;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MAX_LEVEL    = 3'd0;
    localparam logic [2:0] REG_IDLE_LEVEL   = 3'd1;
    localparam logic [2:0] REG_POWER_LEVEL  = 3'd2;
    localparam logic [2:0] REG_SWITCH_LEVEL = 3'd3;
    localparam logic [2:0] REG_MENU_LEVEL   = 3'd4;
    localparam logic [2:0] REG_INC_LEVEL    = 3'd5;
    localparam logic [2:0] REG_DEC_LEVEL    = 3'd6;

    // Selected display input
    localparam logic [1:0] INPUT_VGA = 2'd0;
    localparam logic [1:0] INPUT_AV1 = 2'd1;
    localparam logic [1:0] INPUT_AV2 = 2'd2;

    typedef enum logic [1:0] {
        ACT_PULSE = 2'd0,
        ACT_ON    = 2'd1,
        ACT_OFF   = 2'd2,
        ACT_RESET = 2'd3
    } t_action;

    typedef struct packed {
        logic [TICK_W-1:0] now_tick;
        logic              disp_released;
        logic              disp_long;
        logic              info_released;
        logic              info_long;
        logic              menu_held;
        logic              select_held;
        logic signed [7:0] encoder_step;
    } t_in_item;

    typedef struct packed {
        t_action            action;
        logic [LEVEL_W-1:0] dac_level;
        logic               power_state;
        logic [1:0]         input_state;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] max_level;
        logic [LEVEL_W-1:0] idle_level;
        logic [LEVEL_W-1:0] power_key_level;
        logic [LEVEL_W-1:0] switch_key_level;
        logic [LEVEL_W-1:0] menu_key_level;
        logic [LEVEL_W-1:0] inc_key_level;
        logic [LEVEL_W-1:0] dec_key_level;
    } t_cfg;

    // Limit a level to the configured maximum
    function automatic logic [LEVEL_W-1:0] clamp_level(
        input logic [LEVEL_W-1:0] v,
        input logic [LEVEL_W-1:0] m
    );
        return (v > m) ? m : v;
    endfunction

endpackage

>>> design/dkec_regs.sv
// ----------------------------------------------------------------------------
// dkec_regs
// APB-style register file holding the DAC levels.
// ----------------------------------------------------------------------------
module dkec_regs
    import dkec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[4:2];
    assign w_write = psel & penable & pwrite;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level        <= {LEVEL_W{1'b1}};
            r_cfg.idle_level       <= '0;
            r_cfg.power_key_level  <= '0;
            r_cfg.switch_key_level <= '0;
            r_cfg.menu_key_level   <= '0;
            r_cfg.inc_key_level    <= '0;
            r_cfg.dec_key_level    <= '0;
        end else if (w_write) begin
            case (w_index)
                REG_MAX_LEVEL:    r_cfg.max_level        <= pwdata[LEVEL_W-1:0];
                REG_IDLE_LEVEL:   r_cfg.idle_level       <= pwdata[LEVEL_W-1:0];
                REG_POWER_LEVEL:  r_cfg.power_key_level  <= pwdata[LEVEL_W-1:0];
                REG_SWITCH_LEVEL: r_cfg.switch_key_level <= pwdata[LEVEL_W-1:0];
                REG_MENU_LEVEL:   r_cfg.menu_key_level   <= pwdata[LEVEL_W-1:0];
                REG_INC_LEVEL:    r_cfg.inc_key_level    <= pwdata[LEVEL_W-1:0];
                REG_DEC_LEVEL:    r_cfg.dec_key_level    <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (w_index)
            REG_MAX_LEVEL:    prdata[LEVEL_W-1:0] = r_cfg.max_level;
            REG_IDLE_LEVEL:   prdata[LEVEL_W-1:0] = r_cfg.idle_level;
            REG_POWER_LEVEL:  prdata[LEVEL_W-1:0] = r_cfg.power_key_level;
            REG_SWITCH_LEVEL: prdata[LEVEL_W-1:0] = r_cfg.switch_key_level;
            REG_MENU_LEVEL:   prdata[LEVEL_W-1:0] = r_cfg.menu_key_level;
            REG_INC_LEVEL:    prdata[LEVEL_W-1:0] = r_cfg.inc_key_level;
            REG_DEC_LEVEL:    prdata[LEVEL_W-1:0] = r_cfg.dec_key_level;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> design/dkec_eval.sv
// ----------------------------------------------------------------------------
// dkec_eval
// Poll evaluation: deadlines, power and input state, and up to two results.
// ----------------------------------------------------------------------------
module dkec_eval
    import dkec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res0,
    output t_out_item o_res1,
    output logic [1:0] o_count
);

    logic [TICK_W-1:0] r_menu_dl, n_menu_dl;
    logic [TICK_W-1:0] r_hold_dl, n_hold_dl;
    logic              r_ignore,  n_ignore;
    logic              r_power,   n_power;
    logic [1:0]        r_input,   n_input;

    logic      w_menu_act;
    logic      w_hold_act;
    logic      w_enc_neg;
    logic      w_enc_pos;
    logic      w_v0, w_v1;
    t_out_item w_c0, w_c1;
    logic [1:0] w_next_input;

    assign w_menu_act = i_item.now_tick < r_menu_dl;
    assign w_hold_act = i_item.now_tick < r_hold_dl;
    assign w_enc_neg  = i_item.encoder_step[7];
    assign w_enc_pos  = (i_item.encoder_step != 8'sd0) && !i_item.encoder_step[7];

    // Input advance, modulo 3
    always_comb begin
        case (r_input)
            INPUT_VGA: w_next_input = INPUT_AV1;
            INPUT_AV1: w_next_input = INPUT_AV2;
            INPUT_AV2: w_next_input = INPUT_VGA;
            default:   w_next_input = INPUT_AV1;
        endcase
    end

    // Decision logic; c0 is the early slot, c1 the late one
    always_comb begin
        n_menu_dl = r_menu_dl;
        n_hold_dl = r_hold_dl;
        n_ignore  = r_ignore;
        n_power   = r_power;
        n_input   = r_input;
        w_v0      = 1'b0;
        w_v1      = 1'b0;
        w_c0      = '0;
        w_c1      = '0;
        w_c0.action = ACT_PULSE;
        w_c1.action = ACT_PULSE;

        if (w_menu_act) begin
            // menu navigation
            if (i_item.disp_released) begin
                w_v0 = 1'b1;
                w_c0.dac_level = clamp_level(i_cfg.menu_key_level, i_cfg.max_level);
            end else if (i_item.info_released) begin
                w_v0 = 1'b1;
                w_c0.dac_level = clamp_level(i_cfg.switch_key_level, i_cfg.max_level);
            end
            if (w_enc_neg) begin
                w_v1 = 1'b1;
                w_c1.dac_level = clamp_level(i_cfg.dec_key_level, i_cfg.max_level);
            end else if (w_enc_pos) begin
                w_v1 = 1'b1;
                w_c1.dac_level = clamp_level(i_cfg.inc_key_level, i_cfg.max_level);
            end
            if (w_v0 || w_v1) begin
                n_menu_dl = i_item.now_tick + MENU_WINDOW_TICKS;
            end
        end else if (i_item.disp_released && i_item.menu_held) begin
            // menu entry
            w_v0 = 1'b1;
            w_c0.dac_level = clamp_level(i_cfg.menu_key_level, i_cfg.max_level);
            n_menu_dl = i_item.now_tick + MENU_WINDOW_TICKS;
        end else if (!w_hold_act) begin
            // power key pulse comes first and keeps the old state
            if (i_item.info_long) begin
                w_v0 = 1'b1;
                w_c0.dac_level = clamp_level(i_cfg.power_key_level, i_cfg.max_level);
                n_hold_dl = i_item.now_tick + HOLDOFF_TICKS;
            end
            if (i_item.disp_long && !r_ignore) begin
                n_ignore = 1'b1;
                if (i_item.menu_held && i_item.select_held) begin
                    n_power     = 1'b1;
                    n_input     = INPUT_VGA;
                    w_v1        = 1'b1;
                    w_c1.action = ACT_RESET;
                end else if (r_power) begin
                    n_power     = 1'b0;
                    w_v1        = 1'b1;
                    w_c1.action = ACT_OFF;
                end
            end else if (i_item.disp_released) begin
                if (r_ignore) begin
                    n_ignore = 1'b0;
                end else begin
                    w_v1 = 1'b1;
                    if (!r_power) begin
                        n_power        = 1'b1;
                        w_c1.action    = ACT_ON;
                        w_c1.dac_level = clamp_level(i_cfg.idle_level, i_cfg.max_level);
                    end else begin
                        n_input        = w_next_input;
                        w_c1.dac_level = clamp_level(i_cfg.switch_key_level,
                                                     i_cfg.max_level);
                    end
                    n_hold_dl = i_item.now_tick + HOLDOFF_TICKS;
                end
            end
        end

        w_c0.power_state = r_power;
        w_c0.input_state = r_input;
        w_c1.power_state = n_power;
        w_c1.input_state = n_input;
    end

    // Pack valid slots to the front and mark the final one
    always_comb begin
        o_res0      = w_v0 ? w_c0 : w_c1;
        o_res0.last = !(w_v0 && w_v1);
        o_res1      = w_c1;
        o_res1.last = 1'b1;
        o_count     = {1'b0, w_v0} + {1'b0, w_v1};
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu_dl <= '0;
            r_hold_dl <= '0;
            r_ignore  <= 1'b0;
            r_power   <= 1'b1;
            r_input   <= INPUT_VGA;
        end else if (i_fire) begin
            r_menu_dl <= n_menu_dl;
            r_hold_dl <= n_hold_dl;
            r_ignore  <= n_ignore;
            r_power   <= n_power;
            r_input   <= n_input;
        end
    end

    a_input_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_input != 2'd3)
        else $error("input selection out of range");

    a_off_clears_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_count != 2'd0 && o_res1.action == ACT_OFF && w_v1) |=> !r_power)
        else $error("power off result without power state update");

endmodule

>>> design/display_key_emulation_controller.sv
// ----------------------------------------------------------------------------
// display_key_emulation_controller
// Turns button polls into display key pulses and power actions.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------
//  poll    | in        | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  action  | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//  config  | in        | psel/penable/pwrite     | paddr, pwdata, prdata
//
// A poll is held in the input register and is evaluated once the four-entry
// result queue has room for two results. Sustained rate is one poll per
// cycle for zero or one result while the output is not stalled; polls that
// give two results are slowed by the single output port of the queue.
// Reset is synchronous active low; no clearing pass is needed.
// A stalled output fills the queue and then backs up to o_in_stall.
// ----------------------------------------------------------------------------
module display_key_emulation_controller
    import dkec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      w_cfg;
    t_in_item  r_in;
    logic      r_in_valid, n_in_valid;
    logic      w_accept;
    logic      w_fire;
    logic      w_pop;
    t_out_item w_res0, w_res1;
    logic [1:0] w_count;

    t_out_item              r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr, n_wr;
    logic [FIFO_PTR_W-1:0]  r_rd, n_rd;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic [FIFO_CNT_W-1:0]  w_level;
    logic [FIFO_PTR_W-1:0]  w_wr1;

    dkec_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dkec_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res0  (w_res0),
        .o_res1  (w_res1),
        .o_count (w_count)
    );

    // Handshake: evaluate when the queue can take a full result pair
    assign w_pop      = o_out_valid && !i_out_stall;
    assign w_level    = r_count - {{(FIFO_CNT_W-1){1'b0}}, w_pop};
    assign w_fire     = r_in_valid &&
                        (w_level <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_in_valid = w_accept || (r_in_valid && !w_fire);

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
    end

    // Result queue pointers
    assign w_wr1 = r_wr + 1'b1;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_fire) begin
            n_wr    = r_wr + w_count;
            n_count = r_count + {{(FIFO_CNT_W-2){1'b0}}, w_count};
        end
        if (w_pop) begin
            n_rd    = r_rd + 1'b1;
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (w_fire && w_count != 2'd0) begin
            r_fifo[r_wr] <= w_res0;
        end
        if (w_fire && w_count == 2'd2) begin
            r_fifo[w_wr1] <= w_res1;
        end
    end

    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_fifo[r_rd];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count past depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_count <= FIFO_CNT_W'(FIFO_DEPTH)) && (r_count >= $past(w_level)))
        else $error("result queue overrun");

    a_off_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.action == ACT_OFF) |-> !o_out_data.power_state)
        else $error("power off result with power state set");

endmodule
